// ===== src/blr_pkg.sv =====
// shared constants and types for the bresenham line raster
// no dependencies; used by every module of the block
`default_nettype none

package blr_pkg;

	// default coordinate width and width of the coordinate fields on the ports
	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_BITS     = 16;
	localparam int INK_BITS       = 8;

	// default depth of the command queue between setup and stepper
	localparam int QUEUE_DEPTH_DEF = 4;

	// command flags handed from setup to stepper
	typedef struct packed {
		logic start;      // load a new line, otherwise advance one pixel
		logic steep;      // axes swapped, y is the major axis
		logic minor_neg;  // minor coordinate steps downwards
	} cmd_flags_t;

endpackage

`default_nettype wire

// ===== src/blr_front.sv =====
// setup front end: input register and line classification
// depends on blr_pkg; feeds the command queue
`default_nettype none

module blr_front #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input item side
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic                               start_req,
	input  wire logic signed [COORD_BITS-1:0]       from_x,
	input  wire logic signed [COORD_BITS-1:0]       from_y,
	input  wire logic signed [COORD_BITS-1:0]       to_x,
	input  wire logic signed [COORD_BITS-1:0]       to_y,
	input  wire logic [blr_pkg::INK_BITS-1:0]       ink,
	// command side
	output logic                                    cmd_valid,
	input  wire logic                               cmd_full,
	output blr_pkg::cmd_flags_t                     cmd_flags,
	output logic signed [COORD_BITS-1:0]            cmd_major_pos,
	output logic signed [COORD_BITS-1:0]            cmd_major_end,
	output logic signed [COORD_BITS-1:0]            cmd_minor_pos,
	output logic [COORD_BITS:0]                     cmd_major_span,
	output logic [COORD_BITS:0]                     cmd_minor_span,
	output logic [blr_pkg::INK_BITS-1:0]            cmd_ink
);

	localparam int DW = COORD_BITS + 1;

	logic                               valid_s1;
	logic                               start_s1;
	logic signed [COORD_BITS-1:0]       ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [DW-1:0]               dx_s1, dy_s1;
	logic [blr_pkg::INK_BITS-1:0]       ink_s1;
	logic                               advance;

	logic [DW-1:0]                      adx, ady;
	logic                               steep;
	logic                               swap;
	logic signed [DW-1:0]               dmaj, dmin;
	logic signed [COORD_BITS-1:0]       a_maj, a_min, b_maj, b_min;

	// stage moves on unless it holds an item and the queue is full
	assign advance = !valid_s1 || !cmd_full;
	assign full    = !advance;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	// capture endpoints and form the differences at one extra bit
	always_ff @(posedge clk) begin
		if (push && advance) begin
			start_s1 <= start_req;
			ax_s1    <= from_x;
			ay_s1    <= from_y;
			bx_s1    <= to_x;
			by_s1    <= to_y;
			dx_s1    <= DW'(to_x) - DW'(from_x);
			dy_s1    <= DW'(to_y) - DW'(from_y);
			ink_s1   <= ink;
		end
	end

	// magnitudes and steepness
	assign adx   = dx_s1[DW-1] ? unsigned'(-dx_s1) : unsigned'(dx_s1);
	assign ady   = dy_s1[DW-1] ? unsigned'(-dy_s1) : unsigned'(dy_s1);
	assign steep = ady > adx;

	// pick major and minor axes
	assign dmaj  = steep ? dy_s1 : dx_s1;
	assign dmin  = steep ? dx_s1 : dy_s1;
	assign a_maj = steep ? ay_s1 : ax_s1;
	assign a_min = steep ? ax_s1 : ay_s1;
	assign b_maj = steep ? by_s1 : bx_s1;
	assign b_min = steep ? bx_s1 : by_s1;

	// order endpoints so the major coordinate rises
	assign swap = dmaj[DW-1];

	assign cmd_valid       = valid_s1;
	assign cmd_flags.start = start_s1;
	assign cmd_flags.steep = steep;
	// minor step is negative unless the minor start lies below the minor end
	assign cmd_flags.minor_neg = swap ? !dmin[DW-1] : (dmin[DW-1] || (dmin == '0));
	assign cmd_major_pos  = swap ? b_maj : a_maj;
	assign cmd_major_end  = swap ? a_maj : b_maj;
	assign cmd_minor_pos  = swap ? b_min : a_min;
	assign cmd_major_span = steep ? ady : adx;
	assign cmd_minor_span = steep ? adx : ady;
	assign cmd_ink        = ink_s1;

endmodule

`default_nettype wire

// ===== src/blr_fifo.sv =====
// small command queue between setup and stepper
// depends on blr_pkg for the default depth; depth must be a power of two
`default_nettype none

module blr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = blr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  not_empty
);

	localparam int PTR_BITS = $clog2(DEPTH);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS:0]   wr_ptr_q;
	logic [PTR_BITS:0]   rd_ptr_q;
	logic                do_wr;
	logic                do_rd;

	// wrap bit differs and index matches when full
	assign full      = (wr_ptr_q ^ rd_ptr_q) == {1'b1, PTR_BITS'(0)};
	assign not_empty = wr_ptr_q != rd_ptr_q;
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q[PTR_BITS-1:0]];

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + (PTR_BITS+1)'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + (PTR_BITS+1)'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q[PTR_BITS-1:0]] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/blr_stepper.sv =====
// back end: line state, error update and pixel output register
// depends on blr_pkg; takes commands from the queue
`default_nettype none

module blr_stepper #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// command side
	input  wire logic                               cmd_avail,
	output logic                                    cmd_take,
	input  wire blr_pkg::cmd_flags_t                cmd_flags,
	input  wire logic signed [COORD_BITS-1:0]       cmd_major_pos,
	input  wire logic signed [COORD_BITS-1:0]       cmd_major_end,
	input  wire logic signed [COORD_BITS-1:0]       cmd_minor_pos,
	input  wire logic [COORD_BITS:0]                cmd_major_span,
	input  wire logic [COORD_BITS:0]                cmd_minor_span,
	input  wire logic [blr_pkg::INK_BITS-1:0]       cmd_ink,
	// result side
	output logic                                    empty,
	input  wire logic                               pop,
	output logic signed [blr_pkg::FIELD_BITS-1:0]   pixel_x,
	output logic signed [blr_pkg::FIELD_BITS-1:0]   pixel_y,
	output logic [blr_pkg::INK_BITS-1:0]            pixel_ink,
	output logic                                    last_pixel
);

	localparam int EW = COORD_BITS + 2;

	logic                               busy_q;
	logic                               out_valid_q;
	logic                               steep_q;
	logic                               minor_neg_q;
	logic signed [COORD_BITS-1:0]       major_pos_q;
	logic signed [COORD_BITS-1:0]       major_end_q;
	logic signed [COORD_BITS-1:0]       minor_pos_q;
	logic signed [EW-1:0]               error_q;
	logic signed [EW-1:0]               step_up_q;
	logic [COORD_BITS:0]                minor_span_q;
	logic [blr_pkg::INK_BITS-1:0]       ink_q;

	logic                               out_free;
	logic                               do_load;
	logic                               do_step;
	logic                               at_end;
	logic signed [EW-1:0]               err_dn;
	logic signed [EW-1:0]               err_up;
	logic signed [COORD_BITS-1:0]       minor_nxt;

	// an advance on a live line needs room in the output register
	assign out_free = !out_valid_q || pop;
	assign cmd_take = cmd_avail && (cmd_flags.start || !busy_q || out_free);
	assign do_load  = cmd_take && cmd_flags.start;
	assign do_step  = cmd_take && !cmd_flags.start && busy_q;

	// error update: both outcomes formed side by side
	assign at_end    = major_pos_q == major_end_q;
	assign err_dn    = error_q - signed'({1'b0, minor_span_q});
	assign err_up    = error_q + step_up_q;
	assign minor_nxt = minor_neg_q ? minor_pos_q - COORD_BITS'(1)
	                               : minor_pos_q + COORD_BITS'(1);

	assign empty = !out_valid_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_load) begin
				busy_q <= 1'b1;
			end else if (do_step && at_end) begin
				busy_q <= 1'b0;
			end
			if (do_step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// line state
	always_ff @(posedge clk) begin
		if (do_load) begin
			steep_q      <= cmd_flags.steep;
			minor_neg_q  <= cmd_flags.minor_neg;
			major_pos_q  <= cmd_major_pos;
			major_end_q  <= cmd_major_end;
			minor_pos_q  <= cmd_minor_pos;
			minor_span_q <= cmd_minor_span;
			error_q      <= signed'({2'b00, cmd_major_span[COORD_BITS:1]});
			step_up_q    <= signed'({1'b0, cmd_major_span}) - signed'({1'b0, cmd_minor_span});
			ink_q        <= cmd_ink;
		end else if (do_step) begin
			if (err_dn[EW-1]) begin
				minor_pos_q <= minor_nxt;
				error_q     <= err_up;
			end else begin
				error_q <= err_dn;
			end
			if (!at_end) begin
				major_pos_q <= major_pos_q + COORD_BITS'(1);
			end
		end
	end

	// pixel output register
	always_ff @(posedge clk) begin
		if (do_step) begin
			pixel_x    <= blr_pkg::FIELD_BITS'(steep_q ? minor_pos_q : major_pos_q);
			pixel_y    <= blr_pkg::FIELD_BITS'(steep_q ? major_pos_q : minor_pos_q);
			pixel_ink  <= ink_q;
			last_pixel <= at_end;
		end
	end

endmodule

`default_nettype wire

// ===== src/bresenham_line_raster.sv =====
// top level of the bresenham line raster
// depends on blr_pkg, blr_front, blr_fifo and blr_stepper
`default_nettype none

// Integer Bresenham line rasteriser with queue-style ports on both sides. A start
// item (start_req high) loads two signed endpoints and an ink value and gives no
// pixel; every following advance item gives one pixel, the final one flagged by
// last_pixel. Advances while no line is active are dropped, and a new start
// abandons a line in progress. Items are taken one per clock while full is low, and
// pixels leave one per clock while pop is high: the per-pixel loop is a single
// registered add-and-compare in the stepper, with both error outcomes formed in
// parallel. An item passes through the setup register, the command queue
// (QUEUE_DEPTH entries) and the pixel output register. Only the low COORD_BITS
// bits of each coordinate are used; output coordinates are sign-extended to 16 bits.
module bresenham_line_raster #(
	parameter int COORD_BITS  = blr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = blr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic                               start_req,
	input  wire logic signed [blr_pkg::FIELD_BITS-1:0] from_x,
	input  wire logic signed [blr_pkg::FIELD_BITS-1:0] from_y,
	input  wire logic signed [blr_pkg::FIELD_BITS-1:0] to_x,
	input  wire logic signed [blr_pkg::FIELD_BITS-1:0] to_y,
	input  wire logic [blr_pkg::INK_BITS-1:0]       ink,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic signed [blr_pkg::FIELD_BITS-1:0]   pixel_x,
	output logic signed [blr_pkg::FIELD_BITS-1:0]   pixel_y,
	output logic [blr_pkg::INK_BITS-1:0]            pixel_ink,
	output logic                                    last_pixel
);

	localparam int CMD_BITS = 3 + 3 * COORD_BITS + 2 * (COORD_BITS + 1) + blr_pkg::INK_BITS;

	// setup outputs
	logic                               f_valid;
	blr_pkg::cmd_flags_t                f_flags;
	logic signed [COORD_BITS-1:0]       f_major_pos, f_major_end, f_minor_pos;
	logic [COORD_BITS:0]                f_major_span, f_minor_span;
	logic [blr_pkg::INK_BITS-1:0]       f_ink;

	// queue
	logic                               q_full;
	logic                               q_not_empty;
	logic                               q_take;
	logic [CMD_BITS-1:0]                q_wr_data;
	logic [CMD_BITS-1:0]                q_rd_data;

	// stepper inputs
	blr_pkg::cmd_flags_t                s_flags;
	logic signed [COORD_BITS-1:0]       s_major_pos, s_major_end, s_minor_pos;
	logic [COORD_BITS:0]                s_major_span, s_minor_span;
	logic [blr_pkg::INK_BITS-1:0]       s_ink;

	blr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.start_req      (start_req),
		.from_x         (from_x[COORD_BITS-1:0]),
		.from_y         (from_y[COORD_BITS-1:0]),
		.to_x           (to_x[COORD_BITS-1:0]),
		.to_y           (to_y[COORD_BITS-1:0]),
		.ink            (ink),
		.cmd_valid      (f_valid),
		.cmd_full       (q_full),
		.cmd_flags      (f_flags),
		.cmd_major_pos  (f_major_pos),
		.cmd_major_end  (f_major_end),
		.cmd_minor_pos  (f_minor_pos),
		.cmd_major_span (f_major_span),
		.cmd_minor_span (f_minor_span),
		.cmd_ink        (f_ink)
	);

	// pack and unpack queue entries
	assign q_wr_data = {f_flags, f_major_pos, f_major_end, f_minor_pos,
	                    f_major_span, f_minor_span, f_ink};
	assign {s_flags, s_major_pos, s_major_end, s_minor_pos,
	        s_major_span, s_minor_span, s_ink} = q_rd_data;

	blr_fifo #(
		.WIDTH (CMD_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (f_valid),
		.wr_data   (q_wr_data),
		.full      (q_full),
		.rd_en     (q_take),
		.rd_data   (q_rd_data),
		.not_empty (q_not_empty)
	);

	blr_stepper #(
		.COORD_BITS (COORD_BITS)
	) u_stepper (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_avail      (q_not_empty),
		.cmd_take       (q_take),
		.cmd_flags      (s_flags),
		.cmd_major_pos  (s_major_pos),
		.cmd_major_end  (s_major_end),
		.cmd_minor_pos  (s_minor_pos),
		.cmd_major_span (s_major_span),
		.cmd_minor_span (s_minor_span),
		.cmd_ink        (s_ink),
		.empty          (empty),
		.pop            (pop),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_ink      (pixel_ink),
		.last_pixel     (last_pixel)
	);

endmodule

`default_nettype wire

// ===== src/blr_checker.sv =====
// port-level checks for the bresenham line raster, bound to the top level
// depends on blr_pkg for field widths
`default_nettype none

module blr_checker (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   full,
	input wire logic                                   empty,
	input wire logic                                   pop,
	input wire logic signed [blr_pkg::FIELD_BITS-1:0]  pixel_x,
	input wire logic signed [blr_pkg::FIELD_BITS-1:0]  pixel_y,
	input wire logic [blr_pkg::INK_BITS-1:0]           pixel_ink,
	input wire logic                                   last_pixel
);

	// no pixel is offered while reset is applied
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("pixel offered during reset");

	// input side is open while reset is applied
	a_reset_not_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("full raised during reset");

	// a waiting pixel stays and holds its fields until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_ink) && $stable(last_pixel)))
		else $error("waiting pixel changed before it was taken");

endmodule

bind bresenham_line_raster blr_checker u_blr_checker (.*);

`default_nettype wire
